/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file, nnps_checker.sv.
// Each macro expands to one labeled concurrent assertion, clocked and reset-qualified.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds on that edge.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

/* rtl/core/nnps_pkg.sv */
// Package for the nearest-neighbor pixel scaler: sizes, codes and beat types.
// No dependencies; used by every module of the block except nnps_ram.
`timescale 1ns / 1ps
`default_nettype none

package nnps_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_SIZE   = 4095;
  localparam int RESET_SIZE     = 256;
  localparam int MIN_SIZE       = 2;

  // field widths
  localparam int SW_W  = 9;   // source size registers
  localparam int DW_W  = 12;  // destination size registers and coordinates
  localparam int SX_W  = 8;   // source coordinates
  localparam int PIX_W = 32;
  localparam int ST_W  = 2;

  // quotient is a source coordinate; numerator is below den << QUO_W
  localparam int QUO_W   = SX_W;
  localparam int NUM_W   = DW_W + QUO_W;
  localparam int PROD_W  = DW_W + SW_W;
  localparam int QCNT_W  = $clog2(QUO_W);

  // row pitch equals MAX_SRC_WIDTH, so the address is {y, x}
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DW_W;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [ST_W-1:0] STATUS_SIZE  = 2'd1;
  localparam logic [ST_W-1:0] STATUS_RANGE = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH,
    CFG_SRC_HEIGHT,
    CFG_DST_WIDTH,
    CFG_DST_HEIGHT
  } cfg_index_t;

  typedef struct packed {
    logic             command;
    logic [SX_W-1:0]  src_x;
    logic [SX_W-1:0]  src_y;
    logic [PIX_W-1:0] pixel_in;
    logic [DW_W-1:0]  dst_x;
    logic [DW_W-1:0]  dst_y;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic [ST_W-1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DW_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

`default_nettype wire

/* rtl/core/nnps_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies; holds the source frame.
`timescale 1ns / 1ps
`default_nettype none

module nnps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/nnps_div.sv */
// Restoring divider, one quotient bit per cycle, shared by both axes.
// Depends on nnps_pkg for widths and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module nnps_div import nnps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DW_W-1:0]   rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [DW_W-1:0]   den_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;

  logic [DW_W:0]     shifted;
  logic [DW_W:0]     diff;
  logic              fits;
  logic [DW_W-1:0]   rem_nxt;
  logic [QUO_W-1:0]  quo_nxt;

  // remainder stays below den, so the shifted value fits DW_W+1 bits
  always_comb begin
    shifted = {rem_r, quo_r[QUO_W-1]};
    diff    = shifted - {1'b0, den_r};
    fits    = !diff[DW_W];
    rem_nxt = fits ? diff[DW_W-1:0] : shifted[DW_W-1:0];
    quo_nxt = {quo_r[QUO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // upper numerator bits start as remainder; low bits shift out as quotient
        rem_r <= req.num[NUM_W-1:QUO_W];
        quo_r <= req.num[QUO_W-1:0];
        den_r <= req.den;
        cnt_r <= QCNT_W'(QUO_W - 1);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

/* rtl/core/nearest_neighbor_pixel_scaler.sv */
// Nearest-neighbor pixel scaler top level: sequencer, config registers, frame RAM.
// Depends on nnps_pkg, nnps_div and nnps_ram.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input beats are taken on start while busy is low. A write beat stores pixel_in
//   at (src_x, src_y); a fetch beat returns the source pixel that (dst_x, dst_y)
//   maps to, top (alpha) byte forced to FF if sizes differ. Every beat gives exactly
//   one result, shown on out_data for one cycle with out_valid high; the receiver
//   cannot stall it. Path from the accepting edge to the result:
//     write, or fetch with a size/range error: result on the next cycle, busy stays low
//     fetch with equal source and destination sizes: ST_READ, then ST_DATA
//     scaled fetch: two passes of multiply, divider load,
//       8 quotient steps and handoff, then the RAM read
//   The scaled fetch is bounded by the single shared restoring divider, one
//   quotient bit per cycle, used once per axis; busy is high meanwhile.
//   cfg_we writes src_width, src_height, dst_width, dst_height by cfg_index.
//   Write config only while idle. Reset sets all sizes to 256 and clears the
//   sequencer; the frame RAM is not cleared and reads garbage until written.

module nearest_neighbor_pixel_scaler import nnps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DLOAD,
    ST_DWAIT,
    ST_READ,
    ST_DATA
  } state_t;

  localparam logic [SW_W-1:0] SW_MAX   = SW_W'(MAX_SRC_WIDTH);
  localparam logic [SW_W-1:0] SH_MAX   = SW_W'(MAX_SRC_HEIGHT);
  localparam logic [DW_W-1:0] DST_MAX  = DW_W'(MAX_DST_SIZE);
  localparam logic [DW_W-1:0] SIZE_MIN = DW_W'(MIN_SIZE);

  state_t           state_r, state_nxt;
  logic             axis_r, axis_nxt;   // 0: x pass, 1: y pass
  logic             same_r, same_nxt;
  logic [DW_W-1:0]  dx_r, dx_nxt;
  logic [DW_W-1:0]  dy_r, dy_nxt;
  logic [SX_W-1:0]  sx_r, sx_nxt;
  logic [SX_W-1:0]  sy_r, sy_nxt;
  logic [NUM_W-1:0] prod_r, prod_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [SW_W-1:0]  src_width_r, src_height_r;
  logic [DW_W-1:0]  dst_width_r, dst_height_r;

  logic [DW_W-1:0]   sw, sh, dw, dh;
  logic              accept;
  logic              size_bad, dst_bad, wr_ok, same;
  logic [PROD_W-1:0] prod_full;

  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0] ram_rdata;

  // saturated sizes, source ones widened to destination width for compares
  always_comb begin
    sw = DW_W'((src_width_r  > SW_MAX)  ? SW_MAX  : src_width_r);
    sh = DW_W'((src_height_r > SH_MAX)  ? SH_MAX  : src_height_r);
    dw = (dst_width_r  > DST_MAX) ? DST_MAX : dst_width_r;
    dh = (dst_height_r > DST_MAX) ? DST_MAX : dst_height_r;
  end

  assign accept   = start && !busy;
  assign size_bad = (sw < SIZE_MIN) || (sh < SIZE_MIN) || (dw < SIZE_MIN) || (dh < SIZE_MIN);
  assign dst_bad  = (in_data.dst_x >= dw) || (in_data.dst_y >= dh);
  assign wr_ok    = (DW_W'(in_data.src_x) < sw) && (DW_W'(in_data.src_y) < sh);
  assign same     = (sw == dw) && (sh == dh);

  // the one multiplier, operands picked by axis
  assign prod_full = PROD_W'(axis_r ? dy_r : dx_r) *
                     PROD_W'(axis_r ? sh[SW_W-1:0] : sw[SW_W-1:0]);

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    same_nxt      = same_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_addr      = {sy_r, sx_r};
    div_req.start = 1'b0;
    div_req.num   = prod_r;
    div_req.den   = axis_r ? dh : dw;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt.pixel_out = '0;
          if (in_data.command == CMD_WRITE) begin
            out_valid_nxt = 1'b1;
            if (wr_ok) begin
              ram_we              = 1'b1;
              ram_addr            = {in_data.src_y, in_data.src_x};
              out_data_nxt.status = STATUS_OK;
            end else begin
              out_data_nxt.status = STATUS_RANGE;
            end
          end else if (size_bad) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STATUS_SIZE;
          end else if (dst_bad) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STATUS_RANGE;
          end else begin
            dx_nxt   = in_data.dst_x;
            dy_nxt   = in_data.dst_y;
            same_nxt = same;
            axis_nxt = 1'b0;
            if (same) begin
              // coordinate is below a source size, so it fits SX_W bits
              sx_nxt    = in_data.dst_x[SX_W-1:0];
              sy_nxt    = in_data.dst_y[SX_W-1:0];
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = prod_full[NUM_W-1:0];
        state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_rsp.done) begin
          if (!axis_r) begin
            sx_nxt    = div_rsp.quo;
            axis_nxt  = 1'b1;
            state_nxt = ST_MUL;
          end else begin
            sy_nxt    = div_rsp.quo;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt.status    = STATUS_OK;
        out_data_nxt.pixel_out = same_r ? ram_rdata
                                        : {ALPHA_OPAQUE, ram_rdata[PIX_W-9:0]};
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      src_width_r  <= SW_W'(RESET_SIZE);
      src_height_r <= SW_W'(RESET_SIZE);
      dst_width_r  <= DW_W'(RESET_SIZE);
      dst_height_r <= DW_W'(RESET_SIZE);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      axis_r      <= axis_nxt;
      same_r      <= same_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      prod_r      <= prod_nxt;
      out_data_r  <= out_data_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SW_W-1:0];
          CFG_SRC_HEIGHT: src_height_r <= cfg_data[SW_W-1:0];
          CFG_DST_WIDTH:  dst_width_r  <= cfg_data[DW_W-1:0];
          CFG_DST_HEIGHT: dst_height_r <= cfg_data[DW_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  nnps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  nnps_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.pixel_in),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* rtl/core/nnps_checker.sv */
// Port-level checks for the scaler, bound to the top level.
// Depends on nnps_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nnps_checker import nnps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  logic status_known;
  logic err_beat;
  logic write_take;

  assign status_known = (out_data.status == STATUS_OK) || (out_data.status == STATUS_SIZE) ||
                        (out_data.status == STATUS_RANGE);
  assign err_beat     = out_valid && (out_data.status != STATUS_OK);
  assign write_take   = start && !busy && (in_data.command == CMD_WRITE);

  // status of a valid result is always a defined code
  `ASSERT_IMP(a_status_code, clk, rst_n, out_valid, status_known)

  // error beats carry a zero pixel
  `ASSERT_IMP(a_err_zero, clk, rst_n, err_beat, out_data.pixel_out == '0)

  // a write beat answers on the next cycle without going busy
  `ASSERT_NXT(a_write_1cyc, clk, rst_n, write_take, out_valid && !busy)

  // a long fetch ends with its result
  `ASSERT_IMP(a_busy_end, clk, rst_n, $fell(busy), out_valid)

  // no result while a fetch is still running
  `ASSERT_IMP(a_busy_quiet, clk, rst_n, busy, !out_valid)

endmodule

bind nearest_neighbor_pixel_scaler nnps_checker u_nnps_checker (.*);

`default_nettype wire
